@@ rtl/utf8_cyrillic_to_latin_core_assert.svh @@
// assertion macros used by the checker file
`ifndef UTF8_CYRILLIC_TO_LATIN_CORE_ASSERT_SVH
`define UTF8_CYRILLIC_TO_LATIN_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define U2L_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u2l assertion failed");

// next-cycle implication, disabled in reset
`define U2L_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u2l assertion failed");

`endif

@@ rtl/u2l_pkg.sv @@
package u2l_pkg;

  localparam int CHAR_W      = 7;
  localparam int CP_W        = 21;
  localparam int QUEUE_DEPTH = 4;

  // code points of interest
  localparam logic [CP_W-1:0] CP_ASCII_END   = 21'h000080;
  localparam logic [CP_W-1:0] CP_YO_CAP      = 21'h000401;
  localparam logic [CP_W-1:0] CP_YO_SMALL    = 21'h000451;
  localparam logic [CP_W-1:0] CP_CAP_FIRST   = 21'h000410;
  localparam logic [CP_W-1:0] CP_CAP_LAST    = 21'h00042F;
  localparam logic [CP_W-1:0] CP_SMALL_FIRST = 21'h000430;
  localparam logic [CP_W-1:0] CP_SMALL_LAST  = 21'h00044F;

  localparam logic [4:0]        SPELL_BASE = 5'h10;
  localparam logic [CHAR_W-1:0] CASE_DIFF  = 7'h20;
  localparam logic [CHAR_W-1:0] CHAR_E_CAP = 7'h45;
  localparam logic [CHAR_W-1:0] CHAR_E     = 7'h65;

  typedef logic [CHAR_W-1:0] char_t;

  // one run of output characters for one decoded code point, chars[0] goes first
  typedef struct packed {
    logic [1:0]      len;
    char_t [2:0]     chars;
  } run_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    run_t run;
  } head_t;

  // latin spelling of one letter, optionally upper case
  function automatic run_t spell(input logic [4:0] idx, input logic up);
    run_t r;
    int   k;
    r = '0;
    case (idx)
      5'd0:  begin r.len = 2'd1; r.chars[0] = 7'h61; end
      5'd1:  begin r.len = 2'd1; r.chars[0] = 7'h62; end
      5'd2:  begin r.len = 2'd1; r.chars[0] = 7'h76; end
      5'd3:  begin r.len = 2'd1; r.chars[0] = 7'h67; end
      5'd4:  begin r.len = 2'd1; r.chars[0] = 7'h64; end
      5'd5:  begin r.len = 2'd1; r.chars[0] = 7'h65; end
      5'd6:  begin r.len = 2'd2; r.chars[0] = 7'h7A; r.chars[1] = 7'h68; end
      5'd7:  begin r.len = 2'd1; r.chars[0] = 7'h7A; end
      5'd8:  begin r.len = 2'd1; r.chars[0] = 7'h69; end
      5'd9:  begin r.len = 2'd1; r.chars[0] = 7'h69; end
      5'd10: begin r.len = 2'd1; r.chars[0] = 7'h6B; end
      5'd11: begin r.len = 2'd1; r.chars[0] = 7'h6C; end
      5'd12: begin r.len = 2'd1; r.chars[0] = 7'h6D; end
      5'd13: begin r.len = 2'd1; r.chars[0] = 7'h6E; end
      5'd14: begin r.len = 2'd1; r.chars[0] = 7'h6F; end
      5'd15: begin r.len = 2'd1; r.chars[0] = 7'h70; end
      5'd16: begin r.len = 2'd1; r.chars[0] = 7'h72; end
      5'd17: begin r.len = 2'd1; r.chars[0] = 7'h73; end
      5'd18: begin r.len = 2'd1; r.chars[0] = 7'h74; end
      5'd19: begin r.len = 2'd1; r.chars[0] = 7'h75; end
      5'd20: begin r.len = 2'd1; r.chars[0] = 7'h66; end
      5'd21: begin r.len = 2'd1; r.chars[0] = 7'h68; end
      5'd22: begin r.len = 2'd1; r.chars[0] = 7'h63; end
      5'd23: begin r.len = 2'd2; r.chars[0] = 7'h63; r.chars[1] = 7'h68; end
      5'd24: begin r.len = 2'd2; r.chars[0] = 7'h73; r.chars[1] = 7'h68; end
      5'd25: begin
        r.len = 2'd3; r.chars[0] = 7'h73; r.chars[1] = 7'h63; r.chars[2] = 7'h68;
      end
      5'd27: begin r.len = 2'd1; r.chars[0] = 7'h79; end
      5'd29: begin r.len = 2'd1; r.chars[0] = 7'h65; end
      5'd30: begin r.len = 2'd2; r.chars[0] = 7'h79; r.chars[1] = 7'h75; end
      5'd31: begin r.len = 2'd2; r.chars[0] = 7'h79; r.chars[1] = 7'h61; end
      // hard and soft signs give nothing
      default: r = '0;
    endcase
    if (up) begin
      for (k = 0; k < 3; k++) begin
        if (2'(k) < r.len) r.chars[k] = r.chars[k] - CASE_DIFF;
      end
    end
    return r;
  endfunction

  // map a complete code point to its output run
  function automatic run_t map_cp(input logic [CP_W-1:0] cp);
    run_t r;
    r = '0;
    if (cp < CP_ASCII_END) begin
      r.len      = 2'd1;
      r.chars[0] = cp[CHAR_W-1:0];
    end else if (cp == CP_YO_CAP) begin
      r.len      = 2'd1;
      r.chars[0] = CHAR_E_CAP;
    end else if (cp == CP_YO_SMALL) begin
      r.len      = 2'd1;
      r.chars[0] = CHAR_E;
    end else if (cp >= CP_CAP_FIRST && cp <= CP_CAP_LAST) begin
      r = spell(5'(cp[4:0] - SPELL_BASE), 1'b1);
    end else if (cp >= CP_SMALL_FIRST && cp <= CP_SMALL_LAST) begin
      r = spell(5'(cp[4:0] - SPELL_BASE), 1'b0);
    end
    return r;
  endfunction

endpackage

@@ rtl/u2l_in_if.sv @@
interface u2l_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

@@ rtl/u2l_out_if.sv @@
interface u2l_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       last_of_run;

  modport source (output valid, output out_char, output last_of_run, input ready);
  modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

@@ rtl/utf8_cyrillic_to_latin_core.sv @@
// utf-8 to latin transliterator, one input byte per transaction
// a byte's first char passes the run queue, then the output register
// throughput: 1 byte per cycle in while the queue has room, 1 char per cycle out
//   unless stalled; a run leaves one char at a time, the queue absorbs bursts
// reset: synchronous rst clears decoder state, run queue and output valid
module utf8_cyrillic_to_latin_core
  import u2l_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  u2l_in_if.sink    text,
  u2l_out_if.source latin
);

  logic  push_valid;
  logic  push_ready;
  run_t  push_run;
  logic  pop;
  head_t head;

  // decode and classify
  u2l_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_run   (push_run)
  );

  // run queue between front and back
  u2l_queue #(.DEPTH(DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_run   (push_run),
    .push_ready (push_ready),
    .pop        (pop),
    .head       (head)
  );

  // serialize runs into output chars
  u2l_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .pop   (pop),
    .latin (latin)
  );

endmodule

@@ rtl/u2l_front.sv @@
module u2l_front
  import u2l_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  u2l_in_if.sink text,
  input  logic  push_ready,
  output logic  push_valid,
  output run_t  push_run
);

  logic [1:0]      pending_count, pending_count_next;
  logic [CP_W-1:0] partial_code_point, partial_code_point_next;
  logic [CP_W-1:0] cp_acc;
  logic [CP_W-1:0] cp_emit;
  logic            emit;
  logic            handled;
  logic [7:0]      b;

  assign text.ready = push_ready;
  assign b          = text.in_byte;

  // utf-8 decode step for the current byte
  always_comb begin
    pending_count_next      = pending_count;
    partial_code_point_next = partial_code_point;
    emit                    = 1'b0;
    handled                 = 1'b0;
    cp_acc                  = {partial_code_point[CP_W-7:0], b[5:0]};
    cp_emit                 = {13'b0, b};
    if (pending_count != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        pending_count_next = pending_count - 2'd1;
        handled            = 1'b1;
        if (pending_count == 2'd1) begin
          emit                    = 1'b1;
          cp_emit                 = cp_acc;
          partial_code_point_next = '0;
        end else begin
          partial_code_point_next = cp_acc;
        end
      end else begin
        pending_count_next      = 2'd0;
        partial_code_point_next = '0;
      end
    end
    if (!handled) begin
      if (!b[7]) begin
        emit = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        pending_count_next      = 2'd1;
        partial_code_point_next = {16'b0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        pending_count_next      = 2'd2;
        partial_code_point_next = {17'b0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        pending_count_next      = 2'd3;
        partial_code_point_next = {18'b0, b[2:0]};
      end
    end
    if (text.end_of_text) begin
      pending_count_next      = 2'd0;
      partial_code_point_next = '0;
    end
  end

  // classify the finished code point into an output run
  always_comb begin
    push_run   = map_cp(cp_emit);
    push_valid = text.valid && push_ready && emit && (push_run.len != 2'd0);
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count      <= 2'd0;
      partial_code_point <= '0;
    end else if (text.valid && text.ready) begin
      pending_count      <= pending_count_next;
      partial_code_point <= partial_code_point_next;
    end
  end

endmodule

@@ rtl/u2l_queue.sv @@
module u2l_queue
  import u2l_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  input  run_t  push_run,
  output logic  push_ready,
  input  logic  pop,
  output head_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  run_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.run   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_run;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (do_push && !do_pop)      count <= count + CW'(1);
      else if (!do_push && do_pop) count <= count - CW'(1);
    end
  end

endmodule

@@ rtl/u2l_back.sv @@
module u2l_back
  import u2l_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  head_t      head,
  output logic       pop,
  u2l_out_if.source  latin
);

  logic       out_valid;
  char_t      out_char;
  logic       last_of_run;
  logic [1:0] idx;
  logic       load;
  logic       is_last;

  assign latin.valid       = out_valid;
  assign latin.out_char    = out_char;
  assign latin.last_of_run = last_of_run;

  // output register takes a new char whenever it is empty or being drained
  always_comb begin
    load    = !out_valid || latin.ready;
    is_last = (idx == head.run.len - 2'd1);
    pop     = load && head.valid && is_last;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= head.valid;
      if (head.valid) idx <= is_last ? 2'd0 : idx + 2'd1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load && head.valid) begin
      out_char    <= head.run.chars[idx];
      last_of_run <= is_last;
    end
  end

endmodule

@@ rtl/u2l_checker.sv @@
`include "utf8_cyrillic_to_latin_core_assert.svh"

module u2l_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_char,
  input logic       last_of_run
);

  logic letter;
  logic past_rst;

  assign letter = (out_char >= 7'h41 && out_char <= 7'h5A) ||
                  (out_char >= 7'h61 && out_char <= 7'h7A);

  // track reset release without relying on disable during the check
  always_ff @(posedge clk) begin
    past_rst <= rst;
  end

  // stalled output transaction holds
  `U2L_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
                   out_valid && $stable(out_char) && $stable(last_of_run))

  // multi-char runs come only from letter spellings
  `U2L_ASSERT_IMPL(a_run_letters, clk, rst, out_valid && !last_of_run, letter)

  // nothing pending right after reset
  `U2L_ASSERT_IMPL(a_reset_empty, clk, rst, past_rst, !out_valid && in_ready)

endmodule

bind utf8_cyrillic_to_latin_core u2l_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (text.ready),
  .out_valid   (latin.valid),
  .out_ready   (latin.ready),
  .out_char    (latin.out_char),
  .last_of_run (latin.last_of_run)
);
